// File: hdl/hpcr_pkg.sv
// ----------------------------------------------------------------------------
// hpcr_pkg
// shared types and constants for the hole punch connect retry block
// ----------------------------------------------------------------------------
package hpcr_pkg;

  localparam int EP_W    = 48;
  localparam int DELAY_W = 16;
  localparam int INIT_W  = 15;
  localparam int LIMIT_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register reset values
  localparam logic [INIT_W-1:0]  RETRY_INITIAL_RST = INIT_W'(100);
  localparam logic [INIT_W-1:0]  RETRY_CAP_RST     = INIT_W'(1600);
  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST   = LIMIT_W'(9);
  localparam logic               OUTGOING_RST      = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_INITIAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_CAP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTGOING         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_ENDPOINT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_ENDPOINT  = 3'd5;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_PROBE_REQ  = 2'd1,
    OP_PROBE_RESP = 2'd2
  } op_t;

  localparam logic PHASE_PROBING   = 1'b0;
  localparam logic PHASE_REPORTING = 1'b1;

  typedef struct packed {
    logic [1:0]      operation;
    logic [EP_W-1:0] from_endpoint;
    logic            probe_kind;
  } in_item_t;

  typedef struct packed {
    logic               send_private_probe;
    logic               send_public_probe;
    logic               send_probe_reply;
    logic               reply_kind;
    logic               delay_valid;
    logic [DELAY_W-1:0] next_delay;
    logic               discarded;
    logic               report_established;
    logic               report_connected;
    logic [EP_W-1:0]    peer_endpoint;
  } out_item_t;

  typedef struct packed {
    logic [INIT_W-1:0]  retry_initial;
    logic [INIT_W-1:0]  retry_cap;
    logic [LIMIT_W-1:0] retry_limit;
    logic               outgoing;
    logic [EP_W-1:0]    private_endpoint;
    logic [EP_W-1:0]    public_endpoint;
  } cfg_t;

  typedef struct packed {
    logic               phase;
    logic [DELAY_W-1:0] retry_delay;
    logic [LIMIT_W-1:0] tries;
    logic               connected;
  } state_t;

endpackage

// File: hdl/hole_punch_connect_retry.sv
// ----------------------------------------------------------------------------
// hole_punch_connect_retry
// retry timer and probe control for one peer-connect attempt
// ----------------------------------------------------------------------------
// path: each transaction is captured in the input register, then its result in the
//   result register; a stalled result holds the transaction in the input register
// throughput: one transaction per cycle while the result register is free or drains;
//   the state update is combinational between the input and result registers
// reset (rst, synchronous): attempt state to probing, delay 100, count 0,
//   not connected; all configuration registers to their defaults
module hole_punch_connect_retry (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [hpcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpcr_pkg::CFG_DATA_W-1:0] cfg_data,
  // event input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hpcr_pkg::in_item_t              in_data,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output hpcr_pkg::out_item_t             out_data
);
  import hpcr_pkg::*;

  cfg_t      cfg;
  state_t    state;
  state_t    state_next;
  in_item_t  in_q;
  logic      in_q_valid;
  out_item_t result;
  logic      advance;

  // configuration registers
  hpcr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // decision logic works on the registered transaction
  hpcr_core u_core (
    .item       (in_q),
    .cfg        (cfg),
    .state      (state),
    .result     (result),
    .state_next (state_next)
  );

  // the held transaction moves on when the result register is free or drains
  assign advance  = in_q_valid && (!out_valid || out_ready);
  // input register takes a transaction when empty or when its current one moves on
  assign in_ready = !in_q_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // attempt state commits together with the result it produced
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PHASE_PROBING;
      state.retry_delay <= {1'b0, RETRY_INITIAL_RST};
      state.tries       <= '0;
      state.connected   <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // a stalled transaction stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q))
    else $error("held transaction lost");

  // once connected the attempt never drops back
  a_connected_sticky: assert property (@(posedge clk) disable iff (rst)
    state.connected |=> state.connected)
    else $error("connected flag cleared");

  // any report leaves the attempt in the reporting phase
  a_report_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.report_established || out_data.report_connected)
      |-> state.phase == PHASE_REPORTING && state.connected)
    else $error("report without reporting phase");

  // at most one kind of outcome per result
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({out_data.delay_valid, out_data.send_probe_reply,
                            out_data.discarded, out_data.report_established,
                            out_data.report_connected}))
    else $error("conflicting outcomes in one result");

  // probes are only requested by a tick
  a_probe_on_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.send_public_probe || out_data.send_private_probe)
      |-> out_data.delay_valid)
    else $error("probe request outside a tick");

endmodule

// File: hdl/hpcr_cfg.sv
// ----------------------------------------------------------------------------
// hpcr_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module hpcr_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hpcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpcr_pkg::CFG_DATA_W-1:0] cfg_data,
  output hpcr_pkg::cfg_t                  cfg
);
  import hpcr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_initial    <= RETRY_INITIAL_RST;
      cfg.retry_cap        <= RETRY_CAP_RST;
      cfg.retry_limit      <= RETRY_LIMIT_RST;
      cfg.outgoing         <= OUTGOING_RST;
      cfg.private_endpoint <= '0;
      cfg.public_endpoint  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RETRY_INITIAL:    cfg.retry_initial    <= cfg_data[INIT_W-1:0];
        REG_RETRY_CAP:        cfg.retry_cap        <= cfg_data[INIT_W-1:0];
        REG_RETRY_LIMIT:      cfg.retry_limit      <= cfg_data[LIMIT_W-1:0];
        REG_OUTGOING:         cfg.outgoing         <= cfg_data[0];
        REG_PRIVATE_ENDPOINT: cfg.private_endpoint <= cfg_data[EP_W-1:0];
        REG_PUBLIC_ENDPOINT:  cfg.public_endpoint  <= cfg_data[EP_W-1:0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

endmodule

// File: hdl/hpcr_core.sv
// ----------------------------------------------------------------------------
// hpcr_core
// per-item decision logic: result and next attempt state
// ----------------------------------------------------------------------------
module hpcr_core (
  input  hpcr_pkg::in_item_t  item,
  input  hpcr_pkg::cfg_t      cfg,
  input  hpcr_pkg::state_t    state,
  output hpcr_pkg::out_item_t result,
  output hpcr_pkg::state_t    state_next
);
  import hpcr_pkg::*;

  logic [DELAY_W-1:0] delay_dbl;
  logic [LIMIT_W-1:0] count_inc;
  logic               timeout;
  logic               known_sender;
  logic [DELAY_W-1:0] init_ext;

  assign init_ext  = {1'b0, cfg.retry_initial};
  // doubling only while below the cap
  assign delay_dbl = (state.retry_delay < {1'b0, cfg.retry_cap}) ?
                     {state.retry_delay[DELAY_W-2:0], 1'b0} : state.retry_delay;
  assign count_inc = state.tries + LIMIT_W'(1);
  // limit reached or delay collapsed to zero
  assign timeout   = (count_inc >= cfg.retry_limit) || (delay_dbl == '0);
  assign known_sender = (item.from_endpoint == cfg.private_endpoint) ||
                        (item.from_endpoint == cfg.public_endpoint);

  always_comb begin
    result     = '0;
    state_next = state;
    unique case (op_t'(item.operation))
      OP_TICK: begin
        result.delay_valid = 1'b1;
        if (state.phase == PHASE_PROBING) begin
          result.send_public_probe  = 1'b1;
          result.send_private_probe = cfg.private_endpoint != cfg.public_endpoint;
        end
        if (timeout) begin
          state_next.tries       = '0;
          state_next.retry_delay = init_ext;
          if (state.phase == PHASE_PROBING) begin
            state_next.phase  = PHASE_REPORTING;
            result.next_delay = init_ext;
          end else begin
            result.next_delay = '0;
          end
        end else begin
          state_next.tries       = count_inc;
          state_next.retry_delay = delay_dbl;
          result.next_delay      = delay_dbl;
        end
      end
      OP_PROBE_REQ: begin
        if (known_sender) begin
          result.send_probe_reply = 1'b1;
          result.reply_kind       = item.probe_kind;
          result.peer_endpoint    = item.from_endpoint;
        end else begin
          result.discarded = 1'b1;
        end
      end
      OP_PROBE_RESP: begin
        if (!state.connected) begin
          state_next.connected   = 1'b1;
          state_next.tries       = '0;
          state_next.retry_delay = init_ext;
          state_next.phase       = PHASE_REPORTING;
          result.report_established = cfg.outgoing;
          result.report_connected   = !cfg.outgoing;
          result.peer_endpoint      = item.from_endpoint;
        end
      end
      default: ; // undefined operation, all-zero result
    endcase
  end

endmodule
